// ----- design/stdp_gwu_pkg.sv -----
// Shared types and constants for the STDP Gaussian-window weight update block.
`default_nettype none
package stdp_gwu_pkg;

   localparam int INDEX_BITS          = 10;
   localparam int EXP_ENTRIES_DEFAULT = 256;
   localparam int CSR_IDX_BITS        = 3;
   localparam int CSR_DATA_BITS       = 32;
   localparam int RSP_LATENCY         = 11;

   localparam logic [30:0] W_MAX = 31'h7FFF_FFFF;

   localparam logic OP_LTP = 1'b0;
   localparam logic OP_LTD = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_LTP_CENTER      = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_LTP_INV_TWO_VAR = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_LTP_THETA_GAIN  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_LTP_PREFACTOR   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_LTD_CENTER      = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_LTD_INV_TWO_VAR = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_LTD_THETA_GAIN  = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_LTD_PREFACTOR   = 3'd7;

   typedef struct packed {
      logic                   op;
      logic [INDEX_BITS-1:0]  synapse_index;
      logic [30:0]            weight;
      logic [30:0]            theta;
      logic signed [31:0]     pre_spike_time;
      logic signed [31:0]     post_spike_time;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]  synapse_index_out;
      logic [30:0]            new_weight;
      logic                   saturated;
   } rsp_type;

   // classified item handed from the front end to the datapath
   typedef struct packed {
      logic                   op;
      logic [INDEX_BITS-1:0]  idx;
      logic [30:0]            weight;
      logic [30:0]            pref;
      logic signed [33:0]     d;
      logic [30:0]            inv;
      logic                   ax_big;
      logic [19:0]            ax;
   } uq_type;

endpackage
`default_nettype wire

// ----- design/stdp_gaussian_weight_update.sv -----
// Top level of the multiplicative STDP weight update with Gaussian timing windows.
// An accepted item passes the front-end register, the queue and the datapath stages before its result strobe.
// Throughput: one item per cycle; busy is low except in the cycle after reset.
// Results cannot be stalled; the queue only decouples the front end from the datapath.
// Reset is synchronous and restores register defaults and empties the pipeline.
`default_nettype none
module stdp_gaussian_weight_update import stdp_gwu_pkg::*; #(
   parameter int EXP_TABLE_ENTRIES = EXP_ENTRIES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic   busy_ff;
   logic   acc;
   logic   fq_valid, qb_valid;
   uq_type fq_item, qb_item;

   always_ff @(posedge clock) busy_ff <= reset;

   assign busy = busy_ff;
   assign acc  = start && !busy_ff;

   stdp_gwu_front u_front (
      .clock, .reset, .acc,
      .req       (req_data),
      .csr_we, .csr_index, .csr_wdata,
      .out_valid (fq_valid),
      .out_item  (fq_item)
   );

   stdp_gwu_queue u_queue (
      .clock, .reset,
      .in_valid  (fq_valid),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_item  (qb_item)
   );

   stdp_gwu_back #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_back (
      .clock, .reset,
      .in_valid  (qb_valid),
      .in_item   (qb_item),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule
`default_nettype wire

// ----- design/stdp_gwu_front.sv -----
// Front end: configuration registers, item capture, window offset and amplitude argument.
`default_nettype none
module stdp_gwu_front import stdp_gwu_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     acc,
   input  wire req_type                  req,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   output logic                          out_valid,
   output uq_type                        out_item
);

   typedef struct packed {
      logic                  op;
      logic [INDEX_BITS-1:0] idx;
      logic [30:0]           weight;
      logic [30:0]           theta;
      logic signed [32:0]    dt;
      logic signed [31:0]    center;
      logic [30:0]           inv;
      logic [30:0]           gain;
      logic [30:0]           pref;
   } fs_type;

   logic signed [31:0] ltp_center_ff, ltd_center_ff;
   logic [30:0] ltp_inv_ff, ltp_gain_ff, ltp_pref_ff;
   logic [30:0] ltd_inv_ff, ltd_gain_ff, ltd_pref_ff;

   fs_type s1_in, s1_ff;
   logic   v1_ff;
   logic signed [32:0] pre_x, post_x;
   logic [61:0] ax_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         ltp_center_ff <= '0;
         ltp_inv_ff    <= 31'd65536;
         ltp_gain_ff   <= 31'd65536;
         ltp_pref_ff   <= '0;
         ltd_center_ff <= '0;
         ltd_inv_ff    <= 31'd65536;
         ltd_gain_ff   <= 31'd65536;
         ltd_pref_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LTP_CENTER:      ltp_center_ff <= csr_wdata;
            REG_LTP_INV_TWO_VAR: ltp_inv_ff    <= csr_wdata[30:0];
            REG_LTP_THETA_GAIN:  ltp_gain_ff   <= csr_wdata[30:0];
            REG_LTP_PREFACTOR:   ltp_pref_ff   <= csr_wdata[30:0];
            REG_LTD_CENTER:      ltd_center_ff <= csr_wdata;
            REG_LTD_INV_TWO_VAR: ltd_inv_ff    <= csr_wdata[30:0];
            REG_LTD_THETA_GAIN:  ltd_gain_ff   <= csr_wdata[30:0];
            REG_LTD_PREFACTOR:   ltd_pref_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pre_x  = 33'(req.pre_spike_time);
      post_x = 33'(req.post_spike_time);
      s1_in.op     = req.op;
      s1_in.idx    = req.synapse_index;
      s1_in.weight = req.weight;
      s1_in.theta  = req.theta;
      if (req.op == OP_LTD) begin
         s1_in.dt     = pre_x - post_x;
         s1_in.center = ltd_center_ff;
         s1_in.inv    = ltd_inv_ff;
         s1_in.gain   = ltd_gain_ff;
         s1_in.pref   = ltd_pref_ff;
      end else begin
         s1_in.dt     = post_x - pre_x;
         s1_in.center = ltp_center_ff;
         s1_in.inv    = ltp_inv_ff;
         s1_in.gain   = ltp_gain_ff;
         s1_in.pref   = ltp_pref_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= acc;
      if (acc) s1_ff <= s1_in;
   end

   always_comb begin
      ax_prod = 62'(s1_ff.theta) * 62'(s1_ff.gain);
      out_item.op     = s1_ff.op;
      out_item.idx    = s1_ff.idx;
      out_item.weight = s1_ff.weight;
      out_item.pref   = s1_ff.pref;
      out_item.d      = 34'(s1_ff.center) - 34'(s1_ff.dt);
      out_item.inv    = s1_ff.inv;
      out_item.ax_big = |ax_prod[61:36];
      out_item.ax     = ax_prod[35:16];
      out_valid       = v1_ff;
   end

endmodule
`default_nettype wire

// ----- design/stdp_gwu_queue.sv -----
// Two-entry item queue between the front end and the datapath.
`default_nettype none
module stdp_gwu_queue import stdp_gwu_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire uq_type in_item,
   output logic        out_valid,
   output uq_type      out_item
);

   uq_type     mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   always_comb begin
      pop       = count_ff != 2'd0;
      wr_ptr_in = wr_ptr_ff ^ in_valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(in_valid) - 2'(pop);
      out_valid = pop;
      out_item  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (in_valid) mem_ff[wr_ptr_ff] <= in_item;
   end

endmodule
`default_nettype wire

// ----- design/stdp_gwu_back.sv -----
// Datapath: Gaussian window, theta amplitude, weight product and saturation.
`default_nettype none
module stdp_gwu_back import stdp_gwu_pkg::*; #(
   parameter int EXP_TABLE_ENTRIES = EXP_ENTRIES_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire uq_type in_item,
   output logic        out_valid,
   output rsp_type     out_rsp
);

   localparam int IW = $clog2(EXP_TABLE_ENTRIES + 1);
   localparam int SW = 20 + IW;
   localparam logic [SW-1:0] N_SW = SW'(EXP_TABLE_ENTRIES);
   localparam longint unsigned EXP_H = (64'd16 << 30) / EXP_TABLE_ENTRIES;

   typedef logic [16:0] rom_type [0:EXP_TABLE_ENTRIES];

   // shift-and-subtract quotient, used only while building the table
   function automatic longint unsigned div_small(longint unsigned num, int unsigned den);
      longint unsigned q, rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= 64'(den)) begin
            rem  = rem - 64'(den);
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic rom_type build_rom();
      rom_type           t;
      longint unsigned   h, term, p, ru;
      longint            r;
      h    = EXP_H;
      term = 64'd1 << 30;
      r    = 64'sd1 << 30;
      p    = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
         term = div_small((term * h) >> 30, k);
         if (k[0]) r = r - longint'(term);
         else      r = r + longint'(term);
      end
      if (r < 0) r = 0;
      ru   = longint'(r);
      t[0] = 17'd65536;
      for (int k = 1; k <= EXP_TABLE_ENTRIES; k++) begin
         p    = (p * ru + (64'd1 << 29)) >> 30;
         t[k] = 17'((p + (64'd1 << 13)) >> 14);
      end
      return t;
   endfunction

   localparam rom_type EXP_ROM = build_rom();

   typedef struct packed {
      logic                  op;
      logic [INDEX_BITS-1:0] idx;
      logic [30:0]           weight;
      logic [45:0]           wp;
      logic                  zinv;
      logic                  dbig;
      logic [17:0]           amp;
   } ct_type;

   logic [8:0] vld_ff;

   // stage 1
   ct_type       ct1_in, ct1_ff;
   logic [33:0]  mag;
   logic [61:0]  wp_prod;
   logic [SW-1:0] sa;
   logic [IW-1:0] ia, ia1;
   logic [63:0]  sq1_ff;
   logic [30:0]  inv1_ff;
   logic [16:0]  aa1_ff, ab1_ff;
   logic [19:0]  af1_ff;
   logic         abig1_ff;
   // stage 2
   ct_type       ct2_ff;
   logic [62:0]  ph_prod, pl_prod;
   logic [62:0]  ph2_ff;
   logic [30:0]  pl2_ff;
   logic [16:0]  aa2_ff;
   logic         alt2_ff, abig2_ff;
   logic [36:0]  adp2_ff;
   // stage 3
   ct_type       ct3_in, ct3_ff;
   logic [63:0]  wx_sum;
   logic [16:0]  ae;
   logic         wbig3_ff;
   logic [19:0]  wx3_ff;
   // stage 4
   ct_type       ct4_ff;
   logic [SW-1:0] sw;
   logic [IW-1:0] iw, iw1;
   logic         wbig4_ff;
   logic [16:0]  wa4_ff, wb4_ff;
   logic [19:0]  wf4_ff;
   // stage 5
   ct_type       ct5_ff;
   logic         wbig5_ff, walt5_ff;
   logic [16:0]  wa5_ff;
   logic [36:0]  wdp5_ff;
   // stage 6
   ct_type       ct6_ff;
   logic [16:0]  g6_in, g6_ff;
   // stage 7
   ct_type       ct7_ff;
   logic [62:0]  m1_prod;
   logic [45:0]  m1_7_ff;
   // stage 8
   logic [63:0]  m2_prod;
   logic         op8_ff;
   logic [INDEX_BITS-1:0] idx8_ff;
   logic [30:0]  w8_ff;
   logic [46:0]  m2_8_ff;
   // stage 9
   logic [48:0]  sum;
   rsp_type      rsp_in, rsp_ff;

   always_comb begin
      mag      = in_item.d[33] ? 34'(-in_item.d) : 34'(in_item.d);
      wp_prod  = 62'(in_item.weight) * 62'(in_item.pref);
      sa       = SW'(in_item.ax) * N_SW;
      ia       = sa[SW-1:20];
      ia1      = ia + IW'(1);
      ct1_in.op     = in_item.op;
      ct1_in.idx    = in_item.idx;
      ct1_in.weight = in_item.weight;
      ct1_in.wp     = wp_prod[61:16];
      ct1_in.zinv   = in_item.inv == '0;
      ct1_in.dbig   = |mag[33:32];
      ct1_in.amp    = '0;
   end

   always_comb begin
      ph_prod = 63'(sq1_ff[63:32]) * 63'(inv1_ff);
      pl_prod = 63'(sq1_ff[31:0]) * 63'(inv1_ff);
   end

   always_comb begin
      wx_sum = 64'(ph2_ff) + 64'(pl2_ff);
      if (abig2_ff)     ae = '0;
      else if (alt2_ff) ae = aa2_ff;
      else              ae = aa2_ff - adp2_ff[36:20];
      ct3_in     = ct2_ff;
      ct3_in.amp = (ct2_ff.op == OP_LTD) ? 18'(ae) : 18'd131072 - 18'(ae);
   end

   always_comb begin
      sw  = SW'(wx3_ff) * N_SW;
      iw  = sw[SW-1:20];
      iw1 = iw + IW'(1);
   end

   always_comb begin
      if (ct5_ff.zinv)                      g6_in = 17'd65536;
      else if (ct5_ff.dbig || wbig5_ff)     g6_in = '0;
      else if (walt5_ff)                    g6_in = wa5_ff;
      else                                  g6_in = wa5_ff - wdp5_ff[36:20];
   end

   always_comb begin
      m1_prod = 63'(ct6_ff.wp) * 63'(g6_ff);
      m2_prod = 64'(m1_7_ff) * 64'(ct7_ff.amp);
   end

   always_comb begin
      if (op8_ff == OP_LTD) sum = 49'(w8_ff) - 49'(m2_8_ff);
      else                  sum = 49'(w8_ff) + 49'(m2_8_ff);
      rsp_in.synapse_index_out = idx8_ff;
      if (sum[48]) begin
         rsp_in.new_weight = '0;
         rsp_in.saturated  = 1'b1;
      end else if (|sum[47:31]) begin
         rsp_in.new_weight = W_MAX;
         rsp_in.saturated  = 1'b1;
      end else begin
         rsp_in.new_weight = sum[30:0];
         rsp_in.saturated  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[7:0], in_valid};

      ct1_ff   <= ct1_in;
      sq1_ff   <= 64'(mag[31:0]) * 64'(mag[31:0]);
      inv1_ff  <= in_item.inv;
      aa1_ff   <= EXP_ROM[ia];
      ab1_ff   <= EXP_ROM[ia1];
      af1_ff   <= sa[19:0];
      abig1_ff <= in_item.ax_big;

      ct2_ff   <= ct1_ff;
      ph2_ff   <= ph_prod;
      pl2_ff   <= pl_prod[62:32];
      aa2_ff   <= aa1_ff;
      alt2_ff  <= aa1_ff < ab1_ff;
      adp2_ff  <= 37'(aa1_ff - ab1_ff) * 37'(af1_ff);
      abig2_ff <= abig1_ff;

      ct3_ff   <= ct3_in;
      wbig3_ff <= |wx_sum[63:20];
      wx3_ff   <= wx_sum[19:0];

      ct4_ff   <= ct3_ff;
      wbig4_ff <= wbig3_ff;
      wa4_ff   <= EXP_ROM[iw];
      wb4_ff   <= EXP_ROM[iw1];
      wf4_ff   <= sw[19:0];

      ct5_ff   <= ct4_ff;
      wbig5_ff <= wbig4_ff;
      wa5_ff   <= wa4_ff;
      walt5_ff <= wa4_ff < wb4_ff;
      wdp5_ff  <= 37'(wa4_ff - wb4_ff) * 37'(wf4_ff);

      ct6_ff   <= ct5_ff;
      g6_ff    <= g6_in;

      ct7_ff   <= ct6_ff;
      m1_7_ff  <= m1_prod[61:16];

      op8_ff   <= ct7_ff.op;
      idx8_ff  <= ct7_ff.idx;
      w8_ff    <= ct7_ff.weight;
      m2_8_ff  <= m2_prod[62:16];

      rsp_ff   <= rsp_in;
   end

   assign out_valid = vld_ff[8];
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

// ----- design/stdp_gwu_checker.sv -----
// Port-level checks for the STDP weight update block, bound to the top level.
`default_nettype none
module stdp_gwu_checker import stdp_gwu_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire req_type                  req_data,
   input wire logic                     rsp_valid,
   input wire rsp_type                  rsp_data,
   input wire logic                     csr_we,
   input wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic acc;
   assign acc = start && !busy;

   a_item_gets_result: assert property (@(posedge clock) disable iff (reset)
      acc |-> ##RSP_LATENCY rsp_valid)
      else $error("accepted item produced no result");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(acc, RSP_LATENCY))
      else $error("result without an accepted item");

   a_sat_clamps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.new_weight == '0 || rsp_data.new_weight == W_MAX))
      else $error("saturated flag with unclamped weight");

endmodule

bind stdp_gaussian_weight_update stdp_gwu_checker u_chk (.*);
`default_nettype wire
